// ===== design/ptd_pkg.sv =====
// Shared types and constants for the point to triangle distance pipeline.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ptd_pkg;

  // working width of the 72-bit products, determinant and numerators
  localparam int W         = 72;
  localparam int DIV_STEPS = 16;
  localparam logic [16:0] Q_ONE = 17'h10000;

  typedef enum logic [1:0] {
    LM_ZERO,
    LM_ONE,
    LM_DIV,
    LM_COMP
  } lane_mode_t;

  typedef struct packed {
    lane_mode_t     mode;
    logic [W-1:0]   num;
    logic [W-1:0]   den;
  } lane_t;

  typedef struct packed {
    logic        comp;
    logic        bad;
    logic [16:0] q;
  } div_res_t;

endpackage

`default_nettype wire

// ===== design/ptd_item_if.sv =====
// Input channel: one triangle and one query point per beat.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface ptd_item_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] vertex0_x, vertex0_y, vertex0_z;
  logic signed [15:0] edge0_x, edge0_y, edge0_z;
  logic signed [15:0] edge1_x, edge1_y, edge1_z;
  logic signed [15:0] point_x, point_y, point_z;

  modport source (output valid, vertex0_x, vertex0_y, vertex0_z, edge0_x, edge0_y, edge0_z,
                  edge1_x, edge1_y, edge1_z, point_x, point_y, point_z, input ready);
  modport sink   (input valid, vertex0_x, vertex0_y, vertex0_z, edge0_x, edge0_y, edge0_z,
                  edge1_x, edge1_y, edge1_z, point_x, point_y, point_z, output ready);
endinterface

`default_nettype wire

// ===== design/ptd_result_if.sv =====
// Output channel: distance, offset and barycentric weights per beat.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface ptd_result_if;
  logic               valid;
  logic               ready;
  logic [35:0]        sq_distance;
  logic signed [17:0] offset_x, offset_y, offset_z;
  logic [16:0]        bary_v0, bary_v1, bary_v2;
  logic               degenerate;

  modport source (output valid, sq_distance, offset_x, offset_y, offset_z,
                  bary_v0, bary_v1, bary_v2, degenerate, input ready);
  modport sink   (input valid, sq_distance, offset_x, offset_y, offset_z,
                  bary_v0, bary_v1, bary_v2, degenerate, output ready);
endinterface

`default_nettype wire

// ===== design/ptd_div.sv =====
// Pipelined clamped Q1.16 divider, one quotient bit per stage.
// Depends on ptd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ptd_div (
  input  wire          clk,
  input  wire          en,
  input  ptd_pkg::lane_t    lane,
  output ptd_pkg::div_res_t res
);
  import ptd_pkg::*;

  typedef struct packed {
    logic [W-1:0] rem;
    logic [W-1:0] den;
    logic [15:0]  q;
    logic         fixed;
    logic [16:0]  fval;
    logic         bad;
    logic         comp;
  } div_stage_t;

  div_stage_t st [0:DIV_STEPS];
  div_stage_t entry_c;

  function automatic div_stage_t div_step(input div_stage_t a);
    logic [W:0] r2;
    div_stage_t b;
    b  = a;
    r2 = {a.rem, 1'b0};
    if (!a.fixed && r2 >= {1'b0, a.den}) begin
      b.rem = W'(r2 - {1'b0, a.den});
      b.q   = {a.q[14:0], 1'b1};
    end else begin
      b.rem = r2[W-1:0];
      b.q   = {a.q[14:0], 1'b0};
    end
    return b;
  endfunction

  always_comb begin
    entry_c       = '0;
    entry_c.den   = lane.den;
    entry_c.rem   = lane.num;
    entry_c.fixed = 1'b1;
    unique case (lane.mode)
      LM_ZERO: entry_c.fval = '0;
      LM_ONE:  entry_c.fval = Q_ONE;
      LM_COMP: entry_c.comp = 1'b1;
      LM_DIV: begin
        if (lane.den[W-1] || lane.den == '0) begin
          entry_c.bad = 1'b1;
        end else if (lane.num[W-1]) begin
          entry_c.fval = '0;
        end else if ($signed(lane.num) >= $signed(lane.den)) begin
          entry_c.fval = Q_ONE;
        end else begin
          entry_c.fixed = 1'b0;
        end
      end
      default: entry_c.fval = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= entry_c;
      for (int k = 1; k <= DIV_STEPS; k++) st[k] <= div_step(st[k-1]);
    end
  end

  assign res.comp = st[DIV_STEPS].comp;
  assign res.bad  = st[DIV_STEPS].bad;
  assign res.q    = st[DIV_STEPS].fixed ? st[DIV_STEPS].fval : {1'b0, st[DIV_STEPS].q};

endmodule

`default_nettype wire

// ===== design/point_triangle_distance_top.sv =====
// Point to triangle squared distance, fully pipelined top level.
// Depends on ptd_pkg, ptd_item_if, ptd_result_if and ptd_div.
// One item per cycle sustained from item beat to result, the
// whole pipeline advancing together whenever the output register is empty or taken.
// The 16 quotient stages of the divider set most of the depth.
// Synchronous reset clears the valid bits only; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module point_triangle_distance_top (
  input  wire clk,
  input  wire rst,
  ptd_item_if.sink     item,
  ptd_result_if.source result
);
  import ptd_pkg::*;

  localparam int LAT   = 7 + DIV_STEPS + 1 + 6;
  localparam int GEO_N = 7 + DIV_STEPS + 3;

  typedef struct packed {
    logic [2:0][16:0] d;
    logic [2:0][15:0] e0;
    logic [2:0][15:0] e1;
  } geo_t;

  typedef struct packed {
    logic signed [33:0] a00, a01, a11, b0, b1;
  } dots_t;

  logic [LAT-1:0] vld;
  logic           en;

  assign en         = !vld[LAT-1] || result.ready;
  assign item.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], item.valid};
    end
  end

  // ---- stage 1: difference vector and per-axis products
  logic signed [15:0] v_in [3], p_in [3], e0_in [3], e1_in [3];
  logic signed [16:0] d_c  [3];
  geo_t               geo_c;
  geo_t               geo_r [0:GEO_N-1];

  assign v_in  = '{item.vertex0_x, item.vertex0_y, item.vertex0_z};
  assign p_in  = '{item.point_x, item.point_y, item.point_z};
  assign e0_in = '{item.edge0_x, item.edge0_y, item.edge0_z};
  assign e1_in = '{item.edge1_x, item.edge1_y, item.edge1_z};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_c[i]      = 17'(v_in[i]) - 17'(p_in[i]);
      geo_c.d[i]  = d_c[i];
      geo_c.e0[i] = e0_in[i];
      geo_c.e1[i] = e1_in[i];
    end
  end

  logic [2:0][32:0] s1_a00, s1_a01, s1_a11, s1_b0, s1_b1;

  always_ff @(posedge clk) begin
    if (en) begin
      geo_r[0] <= geo_c;
      for (int k = 1; k < GEO_N; k++) geo_r[k] <= geo_r[k-1];
      for (int i = 0; i < 3; i++) begin
        s1_a00[i] <= 33'(e0_in[i] * e0_in[i]);
        s1_a01[i] <= 33'(e0_in[i] * e1_in[i]);
        s1_a11[i] <= 33'(e1_in[i] * e1_in[i]);
        s1_b0[i]  <= 33'(d_c[i] * e0_in[i]);
        s1_b1[i]  <= 33'(d_c[i] * e1_in[i]);
      end
    end
  end

  // ---- stage 2: dot products
  function automatic logic signed [33:0] sum3(input logic [2:0][32:0] p);
    sum3 = 34'($signed(p[0])) + 34'($signed(p[1])) + 34'($signed(p[2]));
  endfunction

  dots_t s2_dots;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_dots.a00 <= sum3(s1_a00);
      s2_dots.a01 <= sum3(s1_a01);
      s2_dots.a11 <= sum3(s1_a11);
      s2_dots.b0  <= sum3(s1_b0);
      s2_dots.b1  <= sum3(s1_b1);
    end
  end

  // ---- stage 3: split partial products of the 2x2 system
  function automatic logic signed [51:0] mul_lo(input logic signed [33:0] x, y);
    mul_lo = 52'(x * $signed({1'b0, y[16:0]}));
  endfunction

  function automatic logic signed [51:0] mul_hi(input logic signed [33:0] x, y);
    mul_hi = 52'(x * $signed(y[33:17]));
  endfunction

  logic signed [33:0] fx [6], fy [6];
  logic signed [51:0] s3_lo [6], s3_hi [6];
  logic signed [35:0] s3_denom, s4_denom, s5_denom, s6_denom;
  dots_t              s3_dots, s4_dots, s5_dots, s6_dots;

  assign fx = '{s2_dots.a00, s2_dots.a01, s2_dots.a01, s2_dots.a11, s2_dots.a01, s2_dots.a00};
  assign fy = '{s2_dots.a11, s2_dots.a01, s2_dots.b1, s2_dots.b0, s2_dots.b0, s2_dots.b1};

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 6; k++) begin
        s3_lo[k] <= mul_lo(fx[k], fy[k]);
        s3_hi[k] <= mul_hi(fx[k], fy[k]);
      end
      s3_denom <= 36'(s2_dots.a00) - (36'(s2_dots.a01) <<< 1) + 36'(s2_dots.a11);
      s3_dots  <= s2_dots;
    end
  end

  // ---- stage 4: assemble the products
  logic signed [W-1:0] s4_p [6];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 6; k++) s4_p[k] <= (W'(s3_hi[k]) <<< 17) + W'(s3_lo[k]);
      s4_dots  <= s3_dots;
      s4_denom <= s3_denom;
    end
  end

  // ---- stage 5: determinant and numerators
  logic signed [W-1:0] s5_detr, s5_sn, s5_tn;

  always_ff @(posedge clk) begin
    if (en) begin
      s5_detr  <= s4_p[0] - s4_p[1];
      s5_sn    <= s4_p[2] - s4_p[3];
      s5_tn    <= s4_p[4] - s4_p[5];
      s5_dots  <= s4_dots;
      s5_denom <= s4_denom;
    end
  end

  // ---- stage 6: |det|, sn+tn and the edge sums
  logic signed [W-1:0] s6_det, s6_sum, s6_sn, s6_tn;
  logic signed [34:0]  s6_ta0, s6_ta1, s6_tb0, s6_tb1;
  logic signed [35:0]  s6_num0;

  always_ff @(posedge clk) begin
    if (en) begin
      s6_det   <= s5_detr[W-1] ? -s5_detr : s5_detr;
      s6_sum   <= s5_sn + s5_tn;
      s6_sn    <= s5_sn;
      s6_tn    <= s5_tn;
      s6_ta0   <= 35'(s5_dots.a01) + 35'(s5_dots.b0);
      s6_ta1   <= 35'(s5_dots.a11) + 35'(s5_dots.b1);
      s6_tb0   <= 35'(s5_dots.a01) + 35'(s5_dots.b1);
      s6_tb1   <= 35'(s5_dots.a00) + 35'(s5_dots.b0);
      s6_num0  <= 36'(s5_dots.a11) + 36'(s5_dots.b1) - 36'(s5_dots.a01) - 36'(s5_dots.b0);
      s6_dots  <= s5_dots;
      s6_denom <= s5_denom;
    end
  end

  // ---- stage 7: region decision, one lane each for s and t
  function automatic lane_t const_lane(input lane_mode_t m);
    lane_t l;
    l.mode = m;
    l.num  = '0;
    l.den  = '0;
    return l;
  endfunction

  function automatic lane_t div_lane(input logic signed [W-1:0] n, dd);
    lane_t l;
    l.mode = LM_DIV;
    l.num  = n;
    l.den  = dd;
    return l;
  endfunction

  // minimise along one edge
  function automatic lane_t edge_lane(input logic signed [33:0] b, a);
    logic signed [34:0] nb;
    lane_t              l;
    nb = -35'(b);
    if (!b[33]) begin
      l = const_lane(LM_ZERO);
    end else if (nb >= 35'(a)) begin
      l = const_lane(LM_ONE);
    end else begin
      l = div_lane(W'(nb), W'(a));
    end
    return l;
  endfunction

  logic signed [35:0] num_a, num_b;
  logic               in_tri, sneg, tneg;
  lane_t              ls_c, lt_c, s7_ls, s7_lt;

  assign num_a  = 36'(s6_ta1) - 36'(s6_ta0);
  assign num_b  = 36'(s6_tb1) - 36'(s6_tb0);
  assign in_tri = s6_sum <= s6_det;
  assign sneg   = s6_sn[W-1];
  assign tneg   = s6_tn[W-1];

  always_comb begin
    ls_c = const_lane(LM_ZERO);
    lt_c = const_lane(LM_ZERO);
    if (in_tri) begin
      if (sneg) begin
        if (tneg && s6_dots.b0[33]) ls_c = edge_lane(s6_dots.b0, s6_dots.a00);
        else                        lt_c = edge_lane(s6_dots.b1, s6_dots.a11);
      end else if (tneg) begin
        ls_c = edge_lane(s6_dots.b0, s6_dots.a00);
      end else begin
        ls_c = div_lane(s6_sn, s6_det);
        lt_c = div_lane(s6_tn, s6_det);
      end
    end else if (sneg) begin
      if (s6_ta1 > s6_ta0) begin
        if (num_a >= s6_denom) begin
          ls_c = const_lane(LM_ONE);
        end else begin
          ls_c = div_lane(W'(num_a), W'(s6_denom));
          lt_c = const_lane(LM_COMP);
        end
      end else if (s6_ta1 <= 0) begin
        lt_c = const_lane(LM_ONE);
      end else begin
        lt_c = edge_lane(s6_dots.b1, s6_dots.a11);
      end
    end else if (tneg) begin
      if (s6_tb1 > s6_tb0) begin
        if (num_b >= s6_denom) begin
          lt_c = const_lane(LM_ONE);
        end else begin
          lt_c = div_lane(W'(num_b), W'(s6_denom));
          ls_c = const_lane(LM_COMP);
        end
      end else if (s6_tb1 <= 0) begin
        ls_c = const_lane(LM_ONE);
      end else begin
        ls_c = edge_lane(s6_dots.b0, s6_dots.a00);
      end
    end else begin
      if (s6_num0 <= 0) begin
        lt_c = const_lane(LM_ONE);
      end else if (s6_num0 >= s6_denom) begin
        ls_c = const_lane(LM_ONE);
      end else begin
        ls_c = div_lane(W'(s6_num0), W'(s6_denom));
        lt_c = const_lane(LM_COMP);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_ls <= ls_c;
      s7_lt <= lt_c;
    end
  end

  // ---- stages 8 to 24: dividers
  div_res_t rs, rt;

  ptd_div u_div_s (.clk(clk), .en(en), .lane(s7_ls), .res(rs));
  ptd_div u_div_t (.clk(clk), .en(en), .lane(s7_lt), .res(rt));

  // ---- stage 25: resolve s and t
  logic [16:0] r_s, r_t;
  logic        r_bad;

  always_ff @(posedge clk) begin
    if (en) begin
      r_bad <= rs.bad || rt.bad;
      if (rs.bad || rt.bad) begin
        r_s <= '0;
        r_t <= '0;
      end else begin
        r_s <= rs.comp ? 17'(Q_ONE - rt.q) : rs.q;
        r_t <= rt.comp ? 17'(Q_ONE - rs.q) : rt.q;
      end
    end
  end

  // ---- stage 26: s*E0 and t*E1
  logic signed [33:0] m_ps [3], m_pt [3];
  logic [16:0]        m_s, m_t;
  logic               m_bad;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        m_ps[i] <= 34'($signed({1'b0, r_s}) * $signed(geo_r[GEO_N-2].e0[i]));
        m_pt[i] <= 34'($signed({1'b0, r_t}) * $signed(geo_r[GEO_N-2].e1[i]));
      end
      m_s   <= r_s;
      m_t   <= r_t;
      m_bad <= r_bad;
    end
  end

  // ---- stage 27: full-precision offset and rounded signed integer (Q18.0) offset
  logic signed [35:0] full_c [3];
  logic signed [36:0] rnd_c  [3];
  logic signed [20:0] sh_c   [3];
  logic signed [35:0] f_full [3];
  logic signed [17:0] f_ofs  [3];
  logic [16:0]        f_s, f_t;
  logic               f_bad;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      full_c[i] = (36'($signed(geo_r[GEO_N-1].d[i])) <<< 16) + 36'(m_ps[i]) + 36'(m_pt[i]);
      rnd_c[i]  = 37'(full_c[i]) + 37'sd32768;
      sh_c[i]   = 21'(rnd_c[i] >>> 16);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        f_full[i] <= full_c[i];
        if (sh_c[i] > 21'sd131071)       f_ofs[i] <= 18'sd131071;
        else if (sh_c[i] < -21'sd131072) f_ofs[i] <= -18'sd131072;
        else                             f_ofs[i] <= 18'(sh_c[i]);
      end
      f_s   <= m_s;
      f_t   <= m_t;
      f_bad <= m_bad;
    end
  end

  // ---- stage 28: split squares of |offset|
  logic [35:0] mag_c [3];
  logic [35:0] q_hh [3], q_hl [3], q_ll [3];
  logic signed [17:0] q_ofs [3];
  logic [16:0]  q_s, q_t;
  logic         q_bad;

  always_comb begin
    for (int i = 0; i < 3; i++) mag_c[i] = f_full[i][35] ? 36'(-f_full[i]) : 36'(f_full[i]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        q_hh[i] <= mag_c[i][35:18] * mag_c[i][35:18];
        q_hl[i] <= mag_c[i][35:18] * mag_c[i][17:0];
        q_ll[i] <= mag_c[i][17:0] * mag_c[i][17:0];
      end
      q_ofs <= f_ofs;
      q_s   <= f_s;
      q_t   <= f_t;
      q_bad <= f_bad;
    end
  end

  // ---- stage 29: per-axis squares
  logic [W-1:0]       sq [3];
  logic signed [17:0] sq_ofs [3];
  logic [16:0]        sq_s, sq_t;
  logic               sq_bad;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++)
        sq[i] <= (W'(q_hh[i]) << 36) + (W'(q_hl[i]) << 19) + W'(q_ll[i]);
      sq_ofs <= q_ofs;
      sq_s   <= q_s;
      sq_t   <= q_t;
      sq_bad <= q_bad;
    end
  end

  // ---- stage 30: sum, round, saturate; output register
  logic [W-1:0]       dist_c;
  logic [17:0]        st_sum_c;
  logic [35:0]        o_dist;
  logic signed [17:0] o_ofs [3];
  logic [16:0]        o_v0, o_v1, o_v2;
  logic               o_bad;

  assign dist_c   = sq[0] + sq[1] + sq[2] + W'(64'h8000_0000);
  assign st_sum_c = 18'(sq_s) + 18'(sq_t);

  always_ff @(posedge clk) begin
    if (en) begin
      o_dist <= (dist_c[W-1:68] != '0) ? '1 : dist_c[67:32];
      o_ofs  <= sq_ofs;
      o_v0   <= (st_sum_c >= 18'(Q_ONE)) ? '0 : 17'(18'(Q_ONE) - st_sum_c);
      o_v1   <= sq_s;
      o_v2   <= sq_t;
      o_bad  <= sq_bad;
    end
  end

  assign result.valid       = vld[LAT-1];
  assign result.sq_distance = o_dist;
  assign result.offset_x    = o_ofs[0];
  assign result.offset_y    = o_ofs[1];
  assign result.offset_z    = o_ofs[2];
  assign result.bary_v0     = o_v0;
  assign result.bary_v1     = o_v1;
  assign result.bary_v2     = o_v2;
  assign result.degenerate  = o_bad;

  // weights always partition unity
  a_bary_sum: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (18'(result.bary_v0) + 18'(result.bary_v1) + 18'(result.bary_v2))
                     == 18'(Q_ONE))
    else $error("barycentric weights do not sum to one");

  a_degen: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.degenerate |-> result.bary_v1 == '0 && result.bary_v2 == '0)
    else $error("degenerate beat with nonzero s or t");

  a_stall: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |-> !item.ready)
    else $error("input taken while output stalled");

endmodule

`default_nettype wire
